// ----- hw/rtl/skst_pkg.sv -----
// skst_pkg: shared constants, codes and controller/datapath interface types
// for the sorted key set table; depends on nothing
`timescale 1ns / 1ps

package skst_pkg;

    localparam int CAPACITY = 4096;
    localparam int KEY_BITS = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = ADDR_W + 1;
    localparam int POS_W    = 12;
    localparam int CNT_W    = 13;
    localparam int ACT_W    = 2;
    localparam int STAT_W   = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_READ   = 2'd2
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic load;
        logic search_rd;
        logic search_upd;
        logic check_rd;
        logic capture;
        logic shift_init;
        logic shift_step;
        logic write_key;
        logic read_rd;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             search_done;
        logic             match;
        logic             full;
        logic             shift_done;
        logic             out_free;
    } dp_stat_t;

endpackage

// ----- hw/rtl/sorted_key_set_table.sv -----
// sorted_key_set_table: ascending set of signed keys with insert, lookup and read
// lookup runs a binary search; insert runs that search, then shifts the keys at and
// above insert position p up by one and writes the key at p (no shift when p = n), n = count
// one transfer at a time: the search loop and the shift sweep over the single
// key store port set the throughput; a new transfer is taken while a result waits
// reset: synchronous active-low aresetn empties the set, no clearing pass
`timescale 1ns / 1ps

module sorted_key_set_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // key[31:0], index[43:32], zero fill
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // found[0], position[12:1], entry_value[44:13],
                                   // entry_count[57:45], zero fill
    output logic [1:0]  m_tuser    // status[1:0]
);
    import skst_pkg::*;

    dp_cmd_t                    cmd;
    dp_stat_t                   stat;
    logic                       found;
    logic [POS_W-1:0]           position;
    logic signed [KEY_BITS-1:0] entry_value;
    logic [CNT_W-1:0]           entry_count;
    logic [STAT_W-1:0]          status;

    skst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_action (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    skst_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .in_action       (s_tuser),
        .in_key          ($signed(s_tdata[31:0])),
        .in_index        (s_tdata[43:32]),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .out_found       (found),
        .out_position    (position),
        .out_entry_value (entry_value),
        .out_entry_count (entry_count),
        .out_status      (status)
    );

    assign m_tdata = {6'd0, entry_count, entry_value, position, found};
    assign m_tuser = status;

endmodule

// ----- hw/rtl/skst_ram.sv -----
// skst_ram: generic single write port, single read port RAM with
// registered read data; no dependencies
`timescale 1ns / 1ps

module skst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/skst_ctrl.sv -----
// skst_ctrl: sequencing state machine for search, shift, write and read
// depends on skst_pkg
`timescale 1ns / 1ps

module skst_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic [1:0]         s_action,
    output logic               s_tready,
    input  skst_pkg::dp_stat_t stat,
    output skst_pkg::dp_cmd_t  cmd
);
    import skst_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_SEARCH_CMP,
        S_CHECK_RD,
        S_CHECK_CMP,
        S_DECIDE,
        S_SHIFT,
        S_WRITE,
        S_READ_RD,
        S_READ_WAIT,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    case (s_action)
                        ACT_INSERT, ACT_LOOKUP: state_next = S_SEARCH;
                        ACT_READ:               state_next = S_READ_RD;
                        default:                state_next = S_DONE;
                    endcase
                end
            end
            S_SEARCH: begin
                if (stat.search_done) begin
                    state_next = S_CHECK_RD;
                end else begin
                    cmd.search_rd = 1'b1;
                    state_next    = S_SEARCH_CMP;
                end
            end
            S_SEARCH_CMP: begin
                cmd.search_upd = 1'b1;
                state_next     = S_SEARCH;
            end
            S_CHECK_RD: begin
                cmd.check_rd = 1'b1;
                state_next   = S_CHECK_CMP;
            end
            S_CHECK_CMP: begin
                cmd.capture = 1'b1;
                state_next  = S_DECIDE;
            end
            S_DECIDE: begin
                if ((stat.action == ACT_INSERT) && !stat.match && !stat.full) begin
                    cmd.shift_init = 1'b1;
                    state_next     = S_SHIFT;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_SHIFT: begin
                if (stat.shift_done) begin
                    state_next = S_WRITE;
                end else begin
                    cmd.shift_step = 1'b1;
                end
            end
            S_WRITE: begin
                cmd.write_key = 1'b1;
                state_next    = S_DONE;
            end
            S_READ_RD: begin
                cmd.read_rd = 1'b1;
                state_next  = S_READ_WAIT;
            end
            S_READ_WAIT: begin
                cmd.capture = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/skst_dp.sv -----
// skst_dp: search bounds, shift pointer, key store and result register
// depends on skst_pkg and skst_ram
`timescale 1ns / 1ps

module skst_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  skst_pkg::dp_cmd_t                    cmd,
    output skst_pkg::dp_stat_t                   stat,
    input  logic [skst_pkg::ACT_W-1:0]           in_action,
    input  logic signed [skst_pkg::KEY_BITS-1:0] in_key,
    input  logic [skst_pkg::POS_W-1:0]           in_index,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic                                 out_found,
    output logic [skst_pkg::POS_W-1:0]           out_position,
    output logic signed [skst_pkg::KEY_BITS-1:0] out_entry_value,
    output logic [skst_pkg::CNT_W-1:0]           out_entry_count,
    output logic [skst_pkg::STAT_W-1:0]          out_status
);
    import skst_pkg::*;

    localparam int CMP_W = COUNT_W + POS_W;

    logic [ACT_W-1:0]           act_reg;
    logic signed [KEY_BITS-1:0] key_reg;
    logic [POS_W-1:0]           idx_reg;
    logic [COUNT_W-1:0]         lo_reg;
    logic [COUNT_W-1:0]         hi_reg;
    logic [COUNT_W-1:0]         count_reg;
    logic [COUNT_W-1:0]         ptr_reg;
    logic [ADDR_W-1:0]          rd_idx_reg;
    logic                       pend_reg;
    logic                       match_reg;
    logic                       inserted_reg;
    logic [KEY_BITS-1:0]        val_reg;

    logic                       out_valid_reg;
    logic                       out_found_reg;
    logic [POS_W-1:0]           out_position_reg;
    logic [KEY_BITS-1:0]        out_value_reg;
    logic [CNT_W-1:0]           out_count_reg;
    logic [STAT_W-1:0]          out_status_reg;

    logic [COUNT_W:0]           mid_sum;
    logic [COUNT_W-1:0]         mid;
    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_waddr;
    logic [KEY_BITS-1:0]        ram_wdata;
    logic [ADDR_W-1:0]          ram_raddr;
    logic [KEY_BITS-1:0]        ram_rdata;
    logic                       in_range;
    logic                       ptr_above;

    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = mid_sum[COUNT_W:1];
    assign in_range  = (CMP_W'(idx_reg) < CMP_W'(count_reg));
    assign ptr_above = (ptr_reg > lo_reg);

    always_comb begin
        ram_raddr = ADDR_W'(lo_reg);
        if (cmd.search_rd) begin
            ram_raddr = ADDR_W'(mid);
        end else if (cmd.read_rd) begin
            ram_raddr = ADDR_W'(idx_reg);
        end else if (cmd.shift_step) begin
            ram_raddr = ADDR_W'(ptr_reg - COUNT_W'(1));
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = rd_idx_reg + ADDR_W'(1);
        ram_wdata = ram_rdata;
        if (cmd.shift_step && pend_reg) begin
            ram_we = 1'b1;
        end else if (cmd.write_key) begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(lo_reg);
            ram_wdata = key_reg;
        end
    end

    skst_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.write_key) begin
                count_reg <= count_reg + COUNT_W'(1);
            end
            if (cmd.shift_init) begin
                pend_reg <= 1'b0;
            end else if (cmd.shift_step) begin
                pend_reg <= ptr_above;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg      <= in_action;
            key_reg      <= in_key;
            idx_reg      <= in_index;
            lo_reg       <= '0;
            hi_reg       <= count_reg;
            match_reg    <= 1'b0;
            inserted_reg <= 1'b0;
        end
        if (cmd.search_upd) begin
            if ($signed(ram_rdata) < key_reg) begin
                lo_reg <= mid + COUNT_W'(1);
            end else begin
                hi_reg <= mid;
            end
        end
        if (cmd.capture) begin
            match_reg <= (lo_reg < count_reg) && (ram_rdata == key_reg);
            val_reg   <= ram_rdata;
        end
        if (cmd.shift_init) begin
            ptr_reg <= count_reg;
        end else if (cmd.shift_step && ptr_above) begin
            ptr_reg    <= ptr_reg - COUNT_W'(1);
            rd_idx_reg <= ADDR_W'(ptr_reg - COUNT_W'(1));
        end
        if (cmd.write_key) begin
            inserted_reg <= 1'b1;
        end
        if (cmd.out_load) begin
            out_found_reg    <= 1'b0;
            out_position_reg <= '0;
            out_value_reg    <= '0;
            out_count_reg    <= CNT_W'(count_reg);
            out_status_reg   <= ST_NOT_FOUND;
            case (act_reg)
                ACT_INSERT: begin
                    if (match_reg) begin
                        out_status_reg   <= ST_DUPLICATE;
                        out_position_reg <= POS_W'(lo_reg);
                    end else if (inserted_reg) begin
                        out_status_reg   <= ST_OK;
                        out_position_reg <= POS_W'(lo_reg);
                    end else begin
                        out_status_reg <= ST_FULL;
                    end
                end
                ACT_LOOKUP: begin
                    if (match_reg) begin
                        out_found_reg    <= 1'b1;
                        out_status_reg   <= ST_OK;
                        out_position_reg <= POS_W'(lo_reg);
                    end
                end
                ACT_READ: begin
                    out_position_reg <= idx_reg;
                    if (in_range) begin
                        out_found_reg  <= 1'b1;
                        out_value_reg  <= val_reg;
                        out_status_reg <= ST_OK;
                    end
                end
                default: begin
                    out_status_reg <= ST_NOT_FOUND;
                end
            endcase
        end
    end

    assign stat.action      = act_reg;
    assign stat.search_done = (lo_reg >= hi_reg);
    assign stat.match       = match_reg;
    assign stat.full        = (count_reg >= COUNT_W'(CAPACITY));
    assign stat.shift_done  = !ptr_above && !pend_reg;
    assign stat.out_free    = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign out_found       = out_found_reg;
    assign out_position    = out_position_reg;
    assign out_entry_value = $signed(out_value_reg);
    assign out_entry_count = out_count_reg;
    assign out_status      = out_status_reg;

endmodule

// ----- sim/tb_sorted_key_set_table.sv -----
// tb_sorted_key_set_table: self-checking testbench for the sorted key set table,
// a directed table followed by random insert, lookup and read traffic and a closing burst
// depends on skst_pkg and sorted_key_set_table
`timescale 1ns / 1ps

module tb_sorted_key_set_table;
    import skst_pkg::*;

    localparam logic [1:0]  ACT_UNUSED = 2'd3;
    localparam logic [31:0] FILL_BASE  = 32'h7000_0000;
    localparam int          RANDOM_ITEMS = 1740;
    localparam int          GROW_LIMIT   = 512;

    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  position;
        logic [31:0]       entry_value;
        logic [CNT_W-1:0]  entry_count;
        status_t           status;
    } result_t;

    typedef struct packed {
        logic [1:0]        act;
        logic [31:0]       key;
        logic [POS_W-1:0]  index;
        logic              typed;
        result_t           want;
    } step_t;

    localparam result_t NO_WANT = '0;
    localparam int N_DIRECTED = 23;

    // typed rows are the ones readable straight off the spec, the rest go to the predictor
    localparam step_t DIRECTED [N_DIRECTED] = '{
        '{ACT_READ,   32'h0000_0000, 12'd0,    1'b1, '{1'b0, 12'd0,    32'h0, 13'd0, ST_NOT_FOUND}},
        '{ACT_LOOKUP, 32'h0000_0000, 12'd0,    1'b1, '{1'b0, 12'd0,    32'h0, 13'd0, ST_NOT_FOUND}},
        '{ACT_UNUSED, 32'hFFFF_FFFF, 12'd4095, 1'b1, '{1'b0, 12'd0,    32'h0, 13'd0, ST_NOT_FOUND}},
        '{ACT_READ,   32'h0000_0000, 12'd4095, 1'b1, '{1'b0, 12'd4095, 32'h0, 13'd0, ST_NOT_FOUND}},
        '{ACT_INSERT, 32'h0000_0000, 12'd0,    1'b1, '{1'b0, 12'd0,    32'h0, 13'd1, ST_OK}},
        '{ACT_INSERT, 32'h7FFF_FFFF, 12'd0,    1'b1, '{1'b0, 12'd1,    32'h0, 13'd2, ST_OK}},
        '{ACT_INSERT, 32'h8000_0000, 12'd0,    1'b1, '{1'b0, 12'd0,    32'h0, 13'd3, ST_OK}},
        '{ACT_INSERT, 32'h0000_0000, 12'd0,    1'b1, '{1'b0, 12'd1,    32'h0, 13'd3, ST_DUPLICATE}},
        '{ACT_INSERT, 32'hFFFF_FFFF, 12'd0,    1'b1, '{1'b0, 12'd1,    32'h0, 13'd4, ST_OK}},
        '{ACT_LOOKUP, 32'h7FFF_FFFF, 12'd0,    1'b1, '{1'b1, 12'd3,    32'h0, 13'd4, ST_OK}},
        '{ACT_LOOKUP, 32'h8000_0000, 12'd0,    1'b1, '{1'b1, 12'd0,    32'h0, 13'd4, ST_OK}},
        '{ACT_LOOKUP, 32'h0000_0001, 12'd0,    1'b1, '{1'b0, 12'd0,    32'h0, 13'd4, ST_NOT_FOUND}},
        '{ACT_READ,   32'h0000_0000, 12'd3,    1'b1,
          '{1'b1, 12'd3, 32'h7FFF_FFFF, 13'd4, ST_OK}},
        '{ACT_READ,   32'hFFFF_FFFF, 12'd0,    1'b1,
          '{1'b1, 12'd0, 32'h8000_0000, 13'd4, ST_OK}},
        '{ACT_READ,   32'h0000_0000, 12'd4,    1'b1, '{1'b0, 12'd4,    32'h0, 13'd4, ST_NOT_FOUND}},
        '{ACT_INSERT, 32'h5555_5555, 12'd0,    1'b0, NO_WANT},
        '{ACT_INSERT, 32'hAAAA_AAAA, 12'd0,    1'b0, NO_WANT},
        '{ACT_INSERT, 32'hFFFF_FFFE, 12'd0,    1'b0, NO_WANT},
        '{ACT_LOOKUP, 32'hAAAA_AAAA, 12'd0,    1'b0, NO_WANT},
        '{ACT_READ,   32'h0000_0000, 12'd2,    1'b0, NO_WANT},
        '{ACT_UNUSED, 32'h0000_0000, 12'd0,    1'b0, NO_WANT},
        '{ACT_INSERT, 32'h7FFF_FFFF, 12'd0,    1'b0, NO_WANT},
        '{ACT_LOOKUP, 32'h8000_0001, 12'd0,    1'b0, NO_WANT}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;

    logic signed [31:0] set_keys [CAPACITY];
    int                 set_size = 0;
    result_t            pending_results [$];
    int                 errors = 0;
    bit                 idle_on = 1'b1;
    int unsigned        stall_left = 0;

    sorted_key_set_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #8_000_000;
        $display("tb_sorted_key_set_table failed");
        $finish;
    end

    // applies one action to the set and returns the result it gives
    function automatic result_t set_action_result(input logic [1:0] act,
                                                  input logic [31:0] key,
                                                  input logic [POS_W-1:0] idx);
        result_t r;
        int      lo;
        int      hi;
        int      mid;
        bit      hit;
        r        = '0;
        r.status = ST_OK;
        lo       = 0;
        hi       = set_size;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (set_keys[mid] < $signed(key))
                lo = mid + 1;
            else
                hi = mid;
        end
        hit = (lo < set_size) && (set_keys[lo] == $signed(key));
        case (act)
            ACT_INSERT: begin
                if (hit) begin
                    r.status   = ST_DUPLICATE;
                    r.position = POS_W'(lo);
                end else if (set_size >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = set_size; i > lo; i--)
                        set_keys[i] = set_keys[i-1];
                    set_keys[lo] = key;
                    set_size++;
                    r.position = POS_W'(lo);
                end
            end
            ACT_LOOKUP: begin
                if (hit) begin
                    r.found    = 1'b1;
                    r.position = POS_W'(lo);
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            ACT_READ: begin
                r.position = idx;
                if (int'(idx) < set_size) begin
                    r.found       = 1'b1;
                    r.entry_value = set_keys[idx];
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            default: r.status = ST_NOT_FOUND;
        endcase
        r.entry_count = CNT_W'(set_size);
        return r;
    endfunction

    function automatic logic [31:0] stored_key();
        if (set_size == 0)
            return $urandom;
        return set_keys[$urandom_range(0, set_size - 1)];
    endfunction

    task automatic send_action(input logic [1:0] act, input logic [31:0] key,
                               input logic [POS_W-1:0] idx, input logic typed,
                               input result_t want);
        result_t predicted;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, idx, key};
        s_tuser  <= act;
        do @(posedge aclk); while (!s_tready);
        predicted = set_action_result(act, key, idx);
        pending_results.push_back(typed ? want : predicted);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // receiver back-pressure in short bursts, only while idle_on is set
    always @(posedge aclk) begin
        if (!idle_on) begin
            m_tready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 5);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[0] !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, m_tdata[0]);
                    errors++;
                end
                if (m_tdata[12:1] !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position, m_tdata[12:1]);
                    errors++;
                end
                if (m_tdata[44:13] !== want.entry_value) begin
                    $error("entry_value: expected %0h, got %0h",
                           want.entry_value, m_tdata[44:13]);
                    errors++;
                end
                if (m_tdata[57:45] !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, m_tdata[57:45]);
                    errors++;
                end
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    errors++;
                end
            end
        end
    end

    initial begin
        int          roll;
        logic [1:0]  act;
        logic [31:0] key;
        logic [11:0] idx;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_action(DIRECTED[i].act, DIRECTED[i].key, DIRECTED[i].index,
                        DIRECTED[i].typed, DIRECTED[i].want);
        s_tvalid <= 1'b0;
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 99) == 0)
                idle_on = !idle_on;
            roll = $urandom_range(0, 99);
            key  = $urandom;
            idx  = 12'($urandom_range(0, 4095));
            if (roll < 35) begin
                act = ACT_INSERT;
                // growth is capped to keep the shift sweeps short
                if (set_size >= GROW_LIMIT || $urandom_range(0, 6) == 0)
                    key = stored_key();
                else if ($urandom_range(0, 1) == 0)
                    key = 32'($urandom_range(0, 127)) - 32'd64;
            end else if (roll < 70) begin
                act = ACT_LOOKUP;
                case ($urandom_range(0, 3))
                    0, 1: key = stored_key();
                    2:    key = stored_key() + ($urandom_range(0, 1) ? 32'd1 : -32'd1);
                    default: ;
                endcase
            end else if (roll < 95) begin
                act = ACT_READ;
                if ($urandom_range(0, 9) != 0)
                    idx = 12'($urandom_range(0, set_size + 2));
            end else begin
                act = ACT_UNUSED;
            end
            send_action(act, key, idx, 1'b0, NO_WANT);
        end
        s_tvalid <= 1'b0;
        drain_results();

        // closing burst with no idling: extremes, stored keys and reads
        idle_on = 1'b0;
        send_action(ACT_INSERT, 32'h7FFF_FFFE, 12'd0, 1'b0, NO_WANT);
        send_action(ACT_INSERT, 32'h8000_0001, 12'd0, 1'b0, NO_WANT);
        send_action(ACT_INSERT, 32'h7FFF_FFFF, 12'd0, 1'b0, NO_WANT);
        send_action(ACT_INSERT, FILL_BASE, 12'd0, 1'b0, NO_WANT);
        send_action(ACT_LOOKUP, 32'h7FFF_FFFF, 12'd0, 1'b0, NO_WANT);
        send_action(ACT_LOOKUP, 32'h8000_0000, 12'd0, 1'b0, NO_WANT);
        send_action(ACT_READ, 32'h0, 12'd4095, 1'b0, NO_WANT);
        send_action(ACT_READ, 32'h0, 12'd0, 1'b0, NO_WANT);
        for (int n = 0; n < 40; n++)
            send_action(ACT_INSERT, $urandom, 12'd0, 1'b0, NO_WANT);
        for (int n = 0; n < 40; n++)
            send_action(ACT_READ, $urandom, 12'($urandom_range(0, 4095)), 1'b0, NO_WANT);
        send_action(ACT_UNUSED, $urandom, 12'($urandom), 1'b0, NO_WANT);
        s_tvalid <= 1'b0;

        drain_results();
        repeat (64) @(posedge aclk);
        if (errors == 0)
            $display("tb_sorted_key_set_table passed");
        else
            $display("tb_sorted_key_set_table failed");
        $finish;
    end

endmodule
